/* hdl/color_box_pixel_histogram_assert.svh */
// ----------------------------------------------------------------------------
// Color box pixel histogram: assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef COLOR_BOX_PIXEL_HISTOGRAM_ASSERT_SVH
`define COLOR_BOX_PIXEL_HISTOGRAM_ASSERT_SVH

// A stalled request keeps valid high and its payload unchanged
`define CBPH_ASSERT_HOLD(lbl, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("stalled request changed");

// Same-cycle implication
`define CBPH_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication
`define CBPH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* hdl/cbph_pkg.sv */
// ----------------------------------------------------------------------------
// Color box pixel histogram: package
// Widths, class codes, color box bounds and shared types.
// ----------------------------------------------------------------------------
package cbph_pkg;

    // Fixed field widths
    localparam int PIX_W             = 8;
    localparam int IN_TDATA_W        = 3 * PIX_W;
    localparam int COUNT_W           = 21;
    localparam int RUN_W             = 11;
    localparam int NUM_CLASSES       = 7;
    localparam int CLS_W             = 3;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

    // Class codes, in output order
    typedef logic [CLS_W-1:0]       cls_idx_t;
    typedef logic [NUM_CLASSES-1:0] hit_vec_t;

    localparam cls_idx_t CLS_ORANGE = 3'd0;
    localparam cls_idx_t CLS_WHITE  = 3'd1;
    localparam cls_idx_t CLS_GRAY   = 3'd2;
    localparam cls_idx_t CLS_GREEN  = 3'd3;
    localparam cls_idx_t CLS_BLUE   = 3'd4;
    localparam cls_idx_t CLS_RED    = 3'd5;
    localparam cls_idx_t CLS_OTHERS = 3'd6;
    localparam cls_idx_t CLS_LAST   = CLS_OTHERS;

    // Color box bounds (inclusive, except WHITE_ABOVE, which is exclusive)
    localparam logic [PIX_W-1:0] ORANGE_R_LO = 8'd240;
    localparam logic [PIX_W-1:0] ORANGE_G_LO = 8'd85;
    localparam logic [PIX_W-1:0] ORANGE_G_HI = 8'd105;
    localparam logic [PIX_W-1:0] ORANGE_B_LO = 8'd11;
    localparam logic [PIX_W-1:0] ORANGE_B_HI = 8'd22;
    localparam logic [PIX_W-1:0] WHITE_ABOVE = 8'd240;
    localparam logic [PIX_W-1:0] GRAY_R_LO   = 8'd180;
    localparam logic [PIX_W-1:0] GRAY_R_HI   = 8'd212;
    localparam logic [PIX_W-1:0] GRAY_G_LO   = 8'd150;
    localparam logic [PIX_W-1:0] GRAY_G_HI   = 8'd185;
    localparam logic [PIX_W-1:0] GRAY_B_LO   = 8'd96;
    localparam logic [PIX_W-1:0] GRAY_B_HI   = 8'd150;
    localparam logic [PIX_W-1:0] GREEN_R_LO  = 8'd80;
    localparam logic [PIX_W-1:0] GREEN_R_HI  = 8'd100;
    localparam logic [PIX_W-1:0] GREEN_G_LO  = 8'd130;
    localparam logic [PIX_W-1:0] GREEN_G_HI  = 8'd200;
    localparam logic [PIX_W-1:0] GREEN_B_LO  = 8'd20;
    localparam logic [PIX_W-1:0] GREEN_B_HI  = 8'd50;
    localparam logic [PIX_W-1:0] BLUE_R_LO   = 8'd9;
    localparam logic [PIX_W-1:0] BLUE_R_HI   = 8'd90;
    localparam logic [PIX_W-1:0] BLUE_G_LO   = 8'd60;
    localparam logic [PIX_W-1:0] BLUE_G_HI   = 8'd125;
    localparam logic [PIX_W-1:0] BLUE_B_LO   = 8'd125;
    localparam logic [PIX_W-1:0] BLUE_B_HI   = 8'd175;
    localparam logic [PIX_W-1:0] RED_R_LO    = 8'd254;
    localparam logic [PIX_W-1:0] RED_GB_HI   = 8'd1;

    // Request into the shared divider
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] denom;
    } div_req_t;

endpackage

/* hdl/color_box_pixel_histogram.sv */
// ----------------------------------------------------------------------------
// Color box pixel histogram
// Pixels are accepted one per cycle. An image-end pixel stalls the input while
// the seven fractions are formed with the shared divider; classes that need no
// division (empty image, or a count at least the denominator) skip it. The
// result waits in an output register; a result still waiting there holds the
// sequencer in its last state and keeps the input stalled.
// Asynchronous active-low reset clears all counters, runs and the sequencer.
// ----------------------------------------------------------------------------
module color_box_pixel_histogram #(
    parameter int FRACTION_BITS = cbph_pkg::FRACTION_BITS_DEF,
    localparam int FRAC_W      = FRACTION_BITS + 1,
    localparam int OUT_DATA_W  = cbph_pkg::NUM_CLASSES * FRAC_W + cbph_pkg::COUNT_W + 1,
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // red, green, blue
    input  logic [cbph_pkg::IN_TDATA_W-1:0] s_tdata,
    // row_end
    input  logic                            s_tuser,
    // image_end
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // orange_fraction, white_fraction, gray_fraction, green_fraction,
    // blue_fraction, red_fraction, others_fraction, border_count,
    // no_pixels_left, zero padding
    output logic [OUT_TDATA_W-1:0]          m_tdata
);

    localparam int CW = cbph_pkg::COUNT_W;
    localparam int RW = cbph_pkg::RUN_W;
    localparam int NC = cbph_pkg::NUM_CLASSES;
    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    cbph_pkg::cls_idx_t cls_reg;
    logic [CW-1:0]      denom_reg;
    logic               none_reg;
    logic               m_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [FRAC_W-1:0]  frac_reg [NC];

    logic [CW-1:0]      class_cnt_reg [NC];
    logic [CW-1:0]      pix_cnt_reg;
    logic [CW-1:0]      border_reg;
    logic [RW-1:0]      lead_reg;
    logic [RW-1:0]      trail_reg;
    logic               lead_done_reg;

    logic [RW-1:0]      lead_next;
    logic [RW-1:0]      trail_next;
    logic               lead_done_next;
    logic [CW:0]        border_sum1;
    logic [CW-1:0]      border_sat1;
    logic [CW:0]        border_sum2;
    logic [CW-1:0]      border_next;

    cbph_pkg::hit_vec_t hit;
    cbph_pkg::div_req_t div_req;
    logic               div_done;
    logic [FRAC_W-1:0]  div_quo;

    logic               in_acc;
    logic               row_close;
    logic               finish_go;
    logic               last_cls;
    logic [CW-1:0]      cls_cnt;
    logic [CW-1:0]      adj_cnt;
    logic               sat_one;
    logic [OUT_TDATA_W-1:0] out_pack;

    // Classifier
    cbph_classify u_classify (
        .red   (s_tdata[7:0]),
        .green (s_tdata[15:8]),
        .blue  (s_tdata[23:16]),
        .hit   (hit)
    );

    // Shared divider
    cbph_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign row_close = s_tuser || s_tlast;
    assign finish_go = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_data_reg;

    // White run tracking and border update for the current pixel
    always_comb
    begin
        lead_next      = lead_reg;
        trail_next     = trail_reg;
        lead_done_next = lead_done_reg;
        if (hit[cbph_pkg::CLS_WHITE])
        begin
            if (!lead_done_reg)
            begin
                if (lead_reg != cbph_pkg::RUN_MAX)
                    lead_next = lead_reg + 1'b1;
            end
            else if (trail_reg != cbph_pkg::RUN_MAX)
            begin
                trail_next = trail_reg + 1'b1;
            end
        end
        else
        begin
            lead_done_next = 1'b1;
            trail_next     = '0;
        end
        border_sum1 = {1'b0, border_reg} + (CW + 1)'(lead_next);
        border_sat1 = border_sum1[CW] ? cbph_pkg::COUNT_MAX : border_sum1[CW-1:0];
        border_sum2 = {1'b0, border_sat1} + (CW + 1)'(trail_next);
        border_next = border_sum2[CW] ? cbph_pkg::COUNT_MAX : border_sum2[CW-1:0];
    end

    // Pixel accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NC; k++)
                class_cnt_reg[k] <= '0;
            pix_cnt_reg   <= '0;
            border_reg    <= '0;
            lead_reg      <= '0;
            trail_reg     <= '0;
            lead_done_reg <= 1'b0;
        end
        else if (finish_go)
        begin
            for (int k = 0; k < NC; k++)
                class_cnt_reg[k] <= '0;
            pix_cnt_reg <= '0;
            border_reg  <= '0;
        end
        else if (in_acc)
        begin
            for (int k = 0; k < NC; k++)
                if (hit[k] && (class_cnt_reg[k] != cbph_pkg::COUNT_MAX))
                    class_cnt_reg[k] <= class_cnt_reg[k] + 1'b1;
            if (pix_cnt_reg != cbph_pkg::COUNT_MAX)
                pix_cnt_reg <= pix_cnt_reg + 1'b1;
            if (row_close)
            begin
                border_reg    <= border_next;
                lead_reg      <= '0;
                trail_reg     <= '0;
                lead_done_reg <= 1'b0;
            end
            else
            begin
                lead_reg      <= lead_next;
                trail_reg     <= trail_next;
                lead_done_reg <= lead_done_next;
            end
        end
    end

    // Current class operand; white has the border removed
    always_comb
    begin
        cls_cnt  = class_cnt_reg[cls_reg];
        adj_cnt  = cls_cnt;
        if (cls_reg == cbph_pkg::CLS_WHITE)
            adj_cnt = (cls_cnt > border_reg) ? cls_cnt - border_reg : '0;
        sat_one  = adj_cnt >= denom_reg;
        last_cls = (cls_reg == cbph_pkg::CLS_LAST);

        div_req.start = (state_reg == ST_LOAD) && !none_reg && !sat_one;
        div_req.count = adj_cnt;
        div_req.denom = denom_reg;
    end

    // Result packing
    always_comb
    begin
        out_pack = '0;
        for (int k = 0; k < NC; k++)
            out_pack[k*FRAC_W +: FRAC_W] = frac_reg[k];
        out_pack[NC*FRAC_W +: CW] = border_reg;
        out_pack[NC*FRAC_W + CW]  = none_reg;
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cls_reg      <= cbph_pkg::CLS_ORANGE;
            denom_reg    <= '0;
            none_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            out_data_reg <= '0;
            for (int k = 0; k < NC; k++)
                frac_reg[k] <= '0;
        end
        else
        begin
            // Output valid: set on a new result, cleared once taken
            if (finish_go)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && s_tlast)
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    denom_reg <= (pix_cnt_reg > border_reg) ? pix_cnt_reg - border_reg : '0;
                    none_reg  <= (pix_cnt_reg <= border_reg);
                    cls_reg   <= cbph_pkg::CLS_ORANGE;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (none_reg || sat_one)
                    begin
                        frac_reg[cls_reg] <= none_reg ? '0 : FRAC_ONE;
                        if (last_cls)
                            state_reg <= ST_FINISH;
                        else
                            cls_reg <= cls_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        frac_reg[cls_reg] <= div_quo;
                        if (last_cls)
                            state_reg <= ST_FINISH;
                        else
                        begin
                            cls_reg   <= cls_reg + 1'b1;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (finish_go)
                    begin
                        out_data_reg <= out_pack;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/cbph_classify.sv */
// ----------------------------------------------------------------------------
// Color box pixel histogram: pixel classifier
// Tests one RGB pixel against the six color boxes and the others class.
// ----------------------------------------------------------------------------
module cbph_classify (
    input  logic [cbph_pkg::PIX_W-1:0] red,
    input  logic [cbph_pkg::PIX_W-1:0] green,
    input  logic [cbph_pkg::PIX_W-1:0] blue,
    output cbph_pkg::hit_vec_t         hit
);

    function automatic logic in_range(
        input logic [cbph_pkg::PIX_W-1:0] v,
        input logic [cbph_pkg::PIX_W-1:0] lo,
        input logic [cbph_pkg::PIX_W-1:0] hi
    );
        return (v >= lo) && (v <= hi);
    endfunction

    // Box tests; upper bounds of 255 are implicit
    always_comb
    begin
        hit = '0;
        hit[cbph_pkg::CLS_ORANGE] = (red >= cbph_pkg::ORANGE_R_LO)
            && in_range(green, cbph_pkg::ORANGE_G_LO, cbph_pkg::ORANGE_G_HI)
            && in_range(blue, cbph_pkg::ORANGE_B_LO, cbph_pkg::ORANGE_B_HI);
        hit[cbph_pkg::CLS_WHITE] = (red > cbph_pkg::WHITE_ABOVE)
            && (green > cbph_pkg::WHITE_ABOVE) && (blue > cbph_pkg::WHITE_ABOVE);
        hit[cbph_pkg::CLS_GRAY] = in_range(red, cbph_pkg::GRAY_R_LO, cbph_pkg::GRAY_R_HI)
            && in_range(green, cbph_pkg::GRAY_G_LO, cbph_pkg::GRAY_G_HI)
            && in_range(blue, cbph_pkg::GRAY_B_LO, cbph_pkg::GRAY_B_HI);
        hit[cbph_pkg::CLS_GREEN] = in_range(red, cbph_pkg::GREEN_R_LO, cbph_pkg::GREEN_R_HI)
            && in_range(green, cbph_pkg::GREEN_G_LO, cbph_pkg::GREEN_G_HI)
            && in_range(blue, cbph_pkg::GREEN_B_LO, cbph_pkg::GREEN_B_HI);
        hit[cbph_pkg::CLS_BLUE] = in_range(red, cbph_pkg::BLUE_R_LO, cbph_pkg::BLUE_R_HI)
            && in_range(green, cbph_pkg::BLUE_G_LO, cbph_pkg::BLUE_G_HI)
            && in_range(blue, cbph_pkg::BLUE_B_LO, cbph_pkg::BLUE_B_HI);
        hit[cbph_pkg::CLS_RED] = (red >= cbph_pkg::RED_R_LO)
            && (green <= cbph_pkg::RED_GB_HI) && (blue <= cbph_pkg::RED_GB_HI);
        // others: none of orange, gray, red, white
        hit[cbph_pkg::CLS_OTHERS] = !(hit[cbph_pkg::CLS_ORANGE] || hit[cbph_pkg::CLS_GRAY]
            || hit[cbph_pkg::CLS_RED] || hit[cbph_pkg::CLS_WHITE]);
    end

endmodule

/* hdl/cbph_divider.sv */
// ----------------------------------------------------------------------------
// Color box pixel histogram: shared divider
// Restoring radix-2 divider, one quotient bit per cycle. Computes
// (count * 2^FRACTION_BITS + denom/2) / denom; caller guarantees count < denom.
// ----------------------------------------------------------------------------
module cbph_divider #(
    parameter int FRACTION_BITS = cbph_pkg::FRACTION_BITS_DEF,
    localparam int FRAC_W = FRACTION_BITS + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cbph_pkg::div_req_t req,
    output logic               done,
    output logic [FRAC_W-1:0]  quotient
);

    localparam int CW     = cbph_pkg::COUNT_W;
    localparam int NUM_W  = CW + FRACTION_BITS + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     den_reg;
    logic [FRAC_W-1:0] quo_reg;

    logic [NUM_W-1:0]  num_init;
    logic [CW:0]       rem_shift;
    logic [CW:0]       rem_diff;
    logic              fits;

    // Rounded dividend and one restoring step
    always_comb
    begin
        num_init  = {1'b0, req.count, {FRACTION_BITS{1'b0}}}
                  + NUM_W'(req.denom >> 1);
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out MSB first, quotient shifts in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= num_init;
            den_reg <= req.denom;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/cbph_checker.sv */
// ----------------------------------------------------------------------------
// Color box pixel histogram: port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "color_box_pixel_histogram_assert.svh"

module cbph_checker #(
    parameter int FRACTION_BITS = cbph_pkg::FRACTION_BITS_DEF,
    localparam int FRAC_W      = FRACTION_BITS + 1,
    localparam int OUT_DATA_W  = cbph_pkg::NUM_CLASSES * FRAC_W + cbph_pkg::COUNT_W + 1,
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int FRACS_W  = cbph_pkg::NUM_CLASSES * FRAC_W;
    localparam int NONE_BIT = FRACS_W + cbph_pkg::COUNT_W;

    // Result held while stalled
    `CBPH_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, m_tdata)

    // Image end starts the division pass, input stalls
    `CBPH_ASSERT_NEXT(a_stall_after_image, s_tvalid && s_tready && s_tlast, !s_tready)

    // Empty image reports all fractions as zero
    `CBPH_ASSERT_IMPLY(a_empty_zero, m_tvalid && m_tdata[NONE_BIT], m_tdata[FRACS_W-1:0] == '0)

    // A new result only comes out of the division pass
    `CBPH_ASSERT_IMPLY(a_result_after_stall, $rose(m_tvalid), $past(!s_tready))

endmodule

bind color_box_pixel_histogram cbph_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_cbph_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
